[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the go-back-N sender. They compile to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define GBN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// expression must never be true outside reset
`define GBN_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define GBN_ASSERT(lbl, clk, rstn, prop, msg)
`define GBN_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

[hw/rtl/gbn_pkg.sv]
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the go-back-N downlink sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // packets in flight ahead of the window start
  localparam int unsigned WINDOW_PACKETS = 8;

  // result queue depth default (must hold the two results of one item)
  localparam int unsigned RES_DEPTH_DEF = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_PACKET_SIZE     = 2'd0;
  localparam logic [1:0] CFG_WINDOW_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_TRANSFER_TIMEOUT = 2'd2;

  // configuration reset values
  localparam logic [7:0]  PACKET_SIZE_RST      = 8'd255;
  localparam logic [15:0] WINDOW_TIMEOUT_RST   = 16'd1000;
  localparam logic [23:0] TRANSFER_TIMEOUT_RST = 24'd60000;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_ACK   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] file_length;
    logic [7:0]  ack_transaction;
    logic [15:0] ack_sequence;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  transaction;
    logic [15:0] sequence_res;
    logic [23:0] byte_offset;
    logic [7:0]  byte_count;
    logic        end_of_file;
    logic        last;
  } out_item_t;

  // results produced by one item: count (0..2) and the two slots
  typedef struct packed {
    logic [1:0] n;
    out_item_t  res0;
    out_item_t  res1;
  } push_t;

endpackage

[hw/rtl/go_back_n_downlink_sender.sv]
// ----------------------------------------------------------------------------
// go_back_n_downlink_sender
// Go-back-N sender control for a downlinked file: start, tick and ack items
// in, packet requests and finish/abort notices out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : items (tick, start, ack) with valid/ready. A start opens a new
//           transaction; each tick may request one packet and may abort the
//           transfer; an ack slides the window or ends the transfer.
//   out_* : results with valid/ready; 'last' marks the final result of an item.
//   cfg_* : register writes (packet size, window and transfer timeouts),
//           one per cycle, no wait; packet size is taken only while idle.
// Results: an item's results are queued as it is taken and reach out_data
//   behind older ones. Throughput: one item per cycle while in_ready is high,
//   i.e. while at least two of the RES_DEPTH queue entries are free. State
//   updates as the item is taken; results drain one per cycle when out_ready is high.
// Receiver stall: results collect in the queue; once fewer than two entries
//   remain, in_ready drops until the receiver takes results again.
// Reset (rst_n low, synchronous): transfer idle, counters and transaction
//   numbers zero, registers at their defaults, queue empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module go_back_n_downlink_sender
  import gbn_pkg::*;
#(
  parameter int unsigned RES_DEPTH = RES_DEPTH_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int unsigned CW = $clog2(RES_DEPTH+1);

  logic          accept;
  logic          pop;
  push_t         push;
  logic [CW-1:0] q_count;

  assign in_ready = (q_count <= CW'(RES_DEPTH-2));
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  gbn_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept),
    .item      (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  gbn_rfifo #(
    .DEPTH (RES_DEPTH)
  ) u_rfifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (out_data),
    .not_empty (out_valid),
    .count     (q_count)
  );

  // checks
  `GBN_NEVER(a_push_without_accept, clk, rst_n, (push.n != 2'd0) && !accept, "result without accepted item")
  `GBN_NEVER(a_queue_overflow, clk, rst_n, q_count > CW'(RES_DEPTH), "result queue overflow")
  `GBN_ASSERT(a_push_shows, clk, rst_n, (push.n != 2'd0) |=> out_valid, "queued result not visible")
  `GBN_NEVER(a_two_results_last, clk, rst_n, (push.n == 2'd2) && push.res0.last, "first of two results marked last")

endmodule

[hw/rtl/gbn_core.sv]
// ----------------------------------------------------------------------------
// gbn_core
// Transfer state, configuration registers and the registered item update.
// Produces up to two results for each accepted item.
// ----------------------------------------------------------------------------
module gbn_core
  import gbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  in_item_t    item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output push_t       push
);

  logic [7:0]  packet_size_r;
  logic [15:0] window_timeout_r;
  logic [23:0] transfer_timeout_r;

  logic        busy_r,    busy_nxt;
  logic [7:0]  next_tr_r, next_tr_nxt;
  logic [7:0]  act_tr_r,  act_tr_nxt;
  logic [15:0] wfirst_r,  wfirst_nxt;
  logic [15:0] wlimit_r,  wlimit_nxt;
  logic [15:0] sidx_r,    sidx_nxt;
  logic        eof_seen_r, eof_seen_nxt;
  logic [15:0] eof_seq_r, eof_seq_nxt;
  logic [23:0] length_r,  length_nxt;
  logic [15:0] welap_r,   welap_nxt;
  logic [23:0] telap_r,   telap_nxt;

  // packet geometry for the current send index
  logic [15:0] dist_send;
  logic [15:0] dist_limit;
  logic [15:0] dist_eof;
  logic [23:0] offset;
  logic [23:0] remaining;
  logic        short_pkt;
  logic        pkt_ok;
  logic        pkt_eof;
  logic [7:0]  pkt_count;
  logic [15:0] welap_inc;
  logic [23:0] telap_inc;
  logic [15:0] dist_ack;
  logic [15:0] ack_next;

  assign dist_send  = sidx_r - wfirst_r;
  assign dist_limit = wlimit_r - wfirst_r;
  assign dist_eof   = eof_seq_r - wfirst_r;
  assign offset     = {8'd0, sidx_r} * {16'd0, packet_size_r};  // fits 24 bits: 65535 * 255
  assign remaining  = length_r - offset;
  assign short_pkt  = remaining < {16'd0, packet_size_r};
  assign pkt_ok     = (dist_send < dist_limit) && (offset <= length_r) &&
                      !(eof_seen_r && (dist_send > dist_eof));
  assign pkt_eof    = short_pkt || (sidx_r == 16'hFFFF);
  assign pkt_count  = short_pkt ? remaining[7:0] : packet_size_r;
  assign welap_inc  = (welap_r == 16'hFFFF)   ? welap_r : welap_r + 16'd1;
  assign telap_inc  = (telap_r == 24'hFFFFFF) ? telap_r : telap_r + 24'd1;
  assign dist_ack   = item.ack_sequence - wfirst_r;
  assign ack_next   = item.ack_sequence + 16'd1;

  // configuration registers; packet size only changes while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_size_r      <= PACKET_SIZE_RST;
      window_timeout_r   <= WINDOW_TIMEOUT_RST;
      transfer_timeout_r <= TRANSFER_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PACKET_SIZE: begin
          if (!busy_r && (cfg_wdata[7:0] != 8'd0)) packet_size_r <= cfg_wdata[7:0];
        end
        CFG_WINDOW_TIMEOUT:   window_timeout_r   <= cfg_wdata[15:0];
        CFG_TRANSFER_TIMEOUT: transfer_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state and results for the accepted item
  always_comb begin
    out_item_t r_pkt;
    out_item_t r_evt;
    logic      have_pkt;
    logic      have_evt;

    busy_nxt     = busy_r;
    next_tr_nxt  = next_tr_r;
    act_tr_nxt   = act_tr_r;
    wfirst_nxt   = wfirst_r;
    wlimit_nxt   = wlimit_r;
    sidx_nxt     = sidx_r;
    eof_seen_nxt = eof_seen_r;
    eof_seq_nxt  = eof_seq_r;
    length_nxt   = length_r;
    welap_nxt    = welap_r;
    telap_nxt    = telap_r;
    have_pkt     = 1'b0;
    have_evt     = 1'b0;

    r_pkt              = '0;
    r_pkt.kind         = KIND_SEND;
    r_pkt.transaction  = act_tr_r;
    r_pkt.sequence_res = sidx_r;
    r_pkt.byte_offset  = offset;
    r_pkt.byte_count   = pkt_count;
    r_pkt.end_of_file  = pkt_eof;
    r_evt              = '0;
    r_evt.kind         = KIND_ABORT;
    r_evt.transaction  = act_tr_r;

    if (go) begin
      case (item.cmd)
        CMD_START: begin
          act_tr_nxt   = next_tr_r;
          next_tr_nxt  = next_tr_r + 8'd1;
          wfirst_nxt   = '0;
          wlimit_nxt   = 16'(WINDOW_PACKETS);
          sidx_nxt     = '0;
          eof_seen_nxt = 1'b0;
          eof_seq_nxt  = '0;
          length_nxt   = item.file_length;
          welap_nxt    = '0;
          telap_nxt    = '0;
          busy_nxt     = 1'b1;
        end
        CMD_TICK: begin
          if (busy_r) begin
            if (pkt_ok) begin
              have_pkt = 1'b1;
              sidx_nxt = sidx_r + 16'd1;
              if (pkt_eof) begin
                eof_seen_nxt = 1'b1;
                eof_seq_nxt  = sidx_r;
              end
            end
            welap_nxt = welap_inc;
            telap_nxt = telap_inc;
            // window timer: go back to window start
            if (welap_inc >= window_timeout_r) begin
              sidx_nxt  = wfirst_r;
              welap_nxt = '0;
            end
            // transfer timer: abort
            if (telap_inc >= transfer_timeout_r) begin
              have_evt = 1'b1;
              busy_nxt = 1'b0;
            end
          end
        end
        CMD_ACK: begin
          if (busy_r && (item.ack_transaction == act_tr_r) && (dist_ack <= dist_limit)) begin
            if (eof_seen_r && (dist_ack >= dist_eof)) begin
              have_evt   = 1'b1;
              r_evt.kind = KIND_DONE;
              busy_nxt   = 1'b0;
            end else begin
              wfirst_nxt = ack_next;
              wlimit_nxt = ack_next + 16'(WINDOW_PACKETS);
              sidx_nxt   = ack_next;
              welap_nxt  = '0;
              telap_nxt  = '0;
            end
          end
        end
        default: ;
      endcase
    end

    // pack results into the leading slots and mark the final one
    r_pkt.last = !have_evt;
    r_evt.last = 1'b1;
    push = '0;
    if (have_pkt) begin
      push.res0 = r_pkt;
      push.res1 = r_evt;
    end else begin
      push.res0 = r_evt;
      push.res1 = r_evt;
    end
    push.n = {1'b0, have_pkt} + {1'b0, have_evt};
  end

  // transfer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      next_tr_r  <= '0;
      act_tr_r   <= '0;
      wfirst_r   <= '0;
      wlimit_r   <= '0;
      sidx_r     <= '0;
      eof_seen_r <= 1'b0;
      eof_seq_r  <= '0;
      length_r   <= '0;
      welap_r    <= '0;
      telap_r    <= '0;
    end else begin
      busy_r     <= busy_nxt;
      next_tr_r  <= next_tr_nxt;
      act_tr_r   <= act_tr_nxt;
      wfirst_r   <= wfirst_nxt;
      wlimit_r   <= wlimit_nxt;
      sidx_r     <= sidx_nxt;
      eof_seen_r <= eof_seen_nxt;
      eof_seq_r  <= eof_seq_nxt;
      length_r   <= length_nxt;
      welap_r    <= welap_nxt;
      telap_r    <= telap_nxt;
    end
  end

endmodule

[hw/rtl/gbn_rfifo.sv]
// ----------------------------------------------------------------------------
// gbn_rfifo
// Result queue: takes up to two results per cycle, hands out one per cycle when popped.
// Head entry drives the output directly from registers.
// ----------------------------------------------------------------------------
module gbn_rfifo
  import gbn_pkg::*;
#(
  parameter int unsigned DEPTH = RES_DEPTH_DEF
)(
  input  logic                       clk,
  input  logic                       rst_n,
  input  push_t                      push,
  input  logic                       pop,
  output out_item_t                  head,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  out_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]   wp1;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  assign wp1 = bump(wp_r);

  // pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    case (push.n)
      2'd1:    wp_nxt = wp1;
      2'd2:    wp_nxt = bump(wp1);
      default: wp_nxt = wp_r;
    endcase
    if (pop) rp_nxt = bump(rp_r);
    cnt_nxt = cnt_r + CW'(push.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage: first result at write pointer, second one after it
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if ((push.n != 2'd0) && (wp_r == PW'(i))) mem_r[i] <= push.res0;
      else if ((push.n == 2'd2) && (wp1 == PW'(i))) mem_r[i] <= push.res1;
    end
  end

  assign head      = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule

[verif/go_back_n_downlink_sender_chk.sv]
// ----------------------------------------------------------------------------
// go_back_n_downlink_sender_chk
// Watches the item, result and register ports of the go-back-N sender, keeps
// its own copy of the window, timer and transaction state, queues the packet
// requests and finish/abort notices each item should cause, and compares
// every result the block hands out against the oldest one still due.
// ----------------------------------------------------------------------------
module go_back_n_downlink_sender_chk
  import gbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output int          mismatch_count,
  output int          due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // register copies
  logic [7:0]  pkt_size;
  logic [15:0] win_timeout;
  logic [23:0] xfer_timeout;

  // transfer state
  logic        busy;
  logic [7:0]  next_txn;
  logic [7:0]  cur_txn;
  logic [15:0] win_first;
  logic [15:0] win_limit;
  logic [15:0] send_idx;
  logic        eof_flag;
  logic [15:0] eof_seq;
  logic [23:0] file_len;
  logic [15:0] win_age;
  logic [23:0] xfer_age;

  out_item_t   due_results[$];
  out_item_t   want;

  function automatic out_item_t sender_result(kind_t k, logic [15:0] seq,
                                              logic [23:0] off, logic [7:0] cnt,
                                              logic eof);
    out_item_t r;
    r.kind         = k;
    r.transaction  = cur_txn;
    r.sequence_res = seq;
    r.byte_offset  = off;
    r.byte_count   = cnt;
    r.end_of_file  = eof;
    r.last         = 1'b0;
    return r;
  endfunction

  // advance the sender by one item and queue what it emits
  task automatic sender_step(input in_item_t it);
    out_item_t   res[$];
    logic [15:0] gap;
    logic [15:0] span;
    logic [15:0] eof_dist;
    logic [31:0] offset;
    logic [31:0] remaining;
    logic [7:0]  cnt;
    logic        eof;
    logic        ok;
    case (it.cmd)
      CMD_START: begin
        cur_txn   = next_txn;
        next_txn  = next_txn + 8'd1;
        win_first = '0;
        win_limit = 16'(WINDOW_PACKETS);
        send_idx  = '0;
        eof_flag  = 1'b0;
        eof_seq   = '0;
        file_len  = it.file_length;
        win_age   = '0;
        xfer_age  = '0;
        busy      = 1'b1;
      end
      CMD_TICK: begin
        if (busy) begin
          gap      = send_idx - win_first;
          span     = win_limit - win_first;
          eof_dist = eof_seq - win_first;
          offset   = 32'(send_idx) * 32'(pkt_size);
          ok = (gap < span) && (offset <= 32'(file_len));
          // nothing past the end-of-file packet once it is known
          if (ok && eof_flag && gap > eof_dist)
            ok = 1'b0;
          if (ok) begin
            remaining = 32'(file_len) - offset;
            cnt = (remaining < 32'(pkt_size)) ? remaining[7:0] : pkt_size;
            // short packet ends the file; sequence space running out truncates it
            eof = (remaining < 32'(pkt_size)) || (send_idx == 16'hFFFF);
            res.push_back(sender_result(KIND_SEND, send_idx, offset[23:0], cnt, eof));
            if (eof) begin
              eof_flag = 1'b1;
              eof_seq  = send_idx;
            end
            send_idx = send_idx + 16'd1;
          end
          // saturating timers
          if (win_age != 16'hFFFF)
            win_age = win_age + 16'd1;
          if (xfer_age != 24'hFFFFFF)
            xfer_age = xfer_age + 24'd1;
          if (win_age >= win_timeout) begin
            send_idx = win_first;
            win_age  = '0;
          end
          if (xfer_age >= xfer_timeout) begin
            res.push_back(sender_result(KIND_ABORT, '0, '0, '0, 1'b0));
            busy = 1'b0;
          end
        end
      end
      CMD_ACK: begin
        if (busy && it.ack_transaction == cur_txn) begin
          gap      = it.ack_sequence - win_first;
          span     = win_limit - win_first;
          eof_dist = eof_seq - win_first;
          if (gap <= span) begin
            if (eof_flag && gap >= eof_dist) begin
              res.push_back(sender_result(KIND_DONE, '0, '0, '0, 1'b0));
              busy = 1'b0;
            end else begin
              win_first = it.ack_sequence + 16'd1;
              win_limit = win_first + 16'(WINDOW_PACKETS);
              send_idx  = win_first;
              win_age   = '0;
              xfer_age  = '0;
            end
          end
        end
      end
      default: ;
    endcase
    if (res.size() > 0)
      res[res.size() - 1].last = 1'b1;
    foreach (res[i])
      due_results.push_back(res[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pkt_size     = PACKET_SIZE_RST;
      win_timeout  = WINDOW_TIMEOUT_RST;
      xfer_timeout = TRANSFER_TIMEOUT_RST;
      busy         = 1'b0;
      next_txn     = '0;
      cur_txn      = '0;
      win_first    = '0;
      win_limit    = '0;
      send_idx     = '0;
      eof_flag     = 1'b0;
      eof_seq      = '0;
      file_len     = '0;
      win_age      = '0;
      xfer_age     = '0;
      due_results.delete();
    end else begin
      // results first: they belong to items taken at earlier edges
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result kind=%0d txn=%0d seq=%0d off=%0d cnt=%0d eof=%0b last=%0b",
                     $realtime, out_data.kind, out_data.transaction, out_data.sequence_res,
                     out_data.byte_offset, out_data.byte_count, out_data.end_of_file,
                     out_data.last);
        end else begin
          want = due_results.pop_front();
          if (out_data.kind !== want.kind || out_data.transaction !== want.transaction ||
              out_data.sequence_res !== want.sequence_res ||
              out_data.byte_offset !== want.byte_offset ||
              out_data.byte_count !== want.byte_count ||
              out_data.end_of_file !== want.end_of_file || out_data.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected kind=%0d txn=%0d seq=%0d off=%0d cnt=%0d eof=%0b last=%0b",
                       want.kind, want.transaction, want.sequence_res, want.byte_offset,
                       want.byte_count, want.end_of_file, want.last);
              $display("  actual   kind=%0d txn=%0d seq=%0d off=%0d cnt=%0d eof=%0b last=%0b",
                       out_data.kind, out_data.transaction, out_data.sequence_res,
                       out_data.byte_offset, out_data.byte_count, out_data.end_of_file,
                       out_data.last);
            end
          end
        end
      end
      // register writes; packet size holds while a transfer runs
      if (cfg_we) begin
        case (cfg_index)
          CFG_PACKET_SIZE:      if (!busy && cfg_wdata[7:0] != 8'd0) pkt_size = cfg_wdata[7:0];
          CFG_WINDOW_TIMEOUT:   win_timeout = cfg_wdata[15:0];
          CFG_TRANSFER_TIMEOUT: xfer_timeout = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        sender_step(in_data);
    end
    due_count = due_results.size();
  end

endmodule

[verif/go_back_n_downlink_sender_tb.sv]
// ----------------------------------------------------------------------------
// go_back_n_downlink_sender_tb
// Drives start, tick and ack items plus register writes into the go-back-N
// sender: a directed opening over empty, exact-multiple and maximum files,
// mismatched and out-of-window acks and zero timeouts, then random transfers
// under three register settings and three idle patterns. A side checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module go_back_n_downlink_sender_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;

  localparam int          RESET_CYCLES = 12;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  int          mismatch_count;
  int          due_count;
  int          cycle_count   = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // what the stimulus believes about the running transfer
  logic [7:0]  txn_issued = '0;
  logic [7:0]  live_txn   = '0;
  logic [15:0] ack_base   = '0;
  int          cur_ps     = 255;

  go_back_n_downlink_sender dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  go_back_n_downlink_sender_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .due_count      (due_count)
  );

  always #1 clk = ~clk;

  // receiver stalls at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // unused fields carry random bits
  function automatic in_item_t noisy_item(logic [1:0] cmd);
    in_item_t it;
    it.cmd             = cmd;
    it.file_length     = 24'($urandom);
    it.ack_transaction = 8'($urandom);
    it.ack_sequence    = 16'($urandom);
    return it;
  endfunction

  // entered and left on a falling edge; valid stays up after acceptance
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic start_xfer(input logic [23:0] len);
    in_item_t it;
    it             = noisy_item(CMD_START);
    it.file_length = len;
    live_txn       = txn_issued;
    txn_issued     = txn_issued + 8'd1;
    ack_base       = '0;
    send_item(it);
  endtask

  task automatic tick();
    send_item(noisy_item(CMD_TICK));
  endtask

  task automatic ack(input logic [7:0] txn, input logic [15:0] seq);
    in_item_t    it;
    logic [15:0] gap;
    it                 = noisy_item(CMD_ACK);
    it.ack_transaction = txn;
    it.ack_sequence    = seq;
    gap                = seq - ack_base;
    if (txn == live_txn && gap <= 16'(WINDOW_PACKETS))
      ack_base = seq + 16'd1;
    send_item(it);
  endtask

  // stop offering items and wait until every due result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    while (due_count != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // abort whatever runs (zero transfer timeout), then load a new setting
  task automatic set_regs(input int ps, input int wt, input int tt);
    drain();
    cfg_write(CFG_TRANSFER_TIMEOUT, '0);
    tick();
    drain();
    cfg_write(CFG_PACKET_SIZE, 24'(ps));
    cfg_write(CFG_WINDOW_TIMEOUT, 24'(wt));
    cfg_write(CFG_TRANSFER_TIMEOUT, 24'(tt));
    cur_ps = ps;
  endtask

  // transfers with mostly well-formed ticks and acks, some noise
  task automatic random_traffic(input int n_items);
    int sent;
    int burst;
    int pick;
    int len;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)
        len = $urandom_range(0, cur_ps * 24);
      else if (pick < 8)
        len = cur_ps * $urandom_range(0, 24);
      else if (pick < 9)
        len = $urandom_range(0, 24'hFFFFFF);
      else
        len = $urandom_range(0, cur_ps * 3);
      start_xfer(24'(len));
      burst = $urandom_range(8, 60);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          tick();
        end else if (pick < 85) begin
          ack(live_txn, ack_base + 16'($urandom_range(0, WINDOW_PACKETS)));
        end else if (pick < 90) begin
          ack(live_txn, 16'($urandom));
        end else if (pick < 93) begin
          ack(8'($urandom), 16'($urandom));
        end else if (pick < 97) begin
          send_item(noisy_item(CMD_UNUSED));
        end else begin
          start_xfer(24'($urandom_range(0, cur_ps * 16)));
        end
      end
      sent += burst + 1;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: sender idles a little, receiver a lot
    send_idle_pct = 29;
    recv_idle_pct = 87;

    // idle block ignores everything
    tick();
    send_item(noisy_item(CMD_UNUSED));
    ack(8'd0, 16'd0);
    // empty file: one empty end-of-file packet, then finish
    start_xfer(24'd0);
    tick();
    tick();
    ack(live_txn + 8'd1, 16'd0);
    ack(live_txn, 16'd0);
    // largest file: out-of-window ack, ack at the window limit
    start_xfer(24'hFFFFFF);
    ack(live_txn, 16'hFFFF);
    tick();
    tick();
    ack(live_txn, 16'(WINDOW_PACKETS));
    tick();
    // restart while busy with an exact multiple of the packet size
    start_xfer(24'd510);
    repeat (4) tick();
    ack(live_txn, 16'd1);
    ack(live_txn, 16'd2);
    drain();
    // zero packet size and an unused index are ignored
    cfg_write(CFG_PACKET_SIZE, '0);
    cfg_write(CFG_UNUSED, 24'hFFFFFF);
    // packet size held while busy; zero timeouts fire on the first tick
    start_xfer(24'd100);
    drain();
    cfg_write(CFG_PACKET_SIZE, 24'd1);
    cfg_write(CFG_WINDOW_TIMEOUT, '0);
    cfg_write(CFG_TRANSFER_TIMEOUT, '0);
    tick();

    set_regs(1, 4, 30);
    random_traffic(370);

    // phase 2: the other way round
    send_idle_pct = 87;
    recv_idle_pct = 29;
    set_regs(37, 16'hFFFF, 20);
    random_traffic(370);

    // phase 3: no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(200, 6, 100);
    random_traffic(360);

    drain();
    if (mismatch_count == 0 && due_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[go_back_n_downlink_sender.f]
+incdir+hw/rtl
hw/rtl/gbn_pkg.sv
hw/rtl/gbn_core.sv
hw/rtl/gbn_rfifo.sv
hw/rtl/go_back_n_downlink_sender.sv
verif/go_back_n_downlink_sender_chk.sv
verif/go_back_n_downlink_sender_tb.sv
